/* rtl/eso_pkg.sv */
// Shared types, constants and tables for the epoch seconds to UTC date unit.
// Used by every module of the block; depends on nothing else.
package eso_pkg;

    localparam int unsigned IN_W   = 40;
    localparam int unsigned DATA_W = 48;

    // Bias that makes every input non-negative: a whole number of days,
    // 6362915 days, just above 2**39 seconds.
    localparam logic [40:0] SEC_BIAS = 41'd549755856000;

    // 86400 = 128 * 675. The odd factor is divided out in two long-division steps.
    localparam logic [9:0]  SEC_DIV_ODD = 10'd675;
    localparam int unsigned HI_SHIFT    = 27;
    localparam logic [17:0] HI_MUL      =
        18'(((64'd1 << HI_SHIFT) + 64'(SEC_DIV_ODD) - 64'd1) / 64'(SEC_DIV_ODD));
    localparam int unsigned LO_SHIFT    = 36;
    localparam logic [26:0] LO_MUL      =
        27'(((64'd1 << LO_SHIFT) + 64'(SEC_DIV_ODD) - 64'd1) / 64'(SEC_DIV_ODD));

    // Biased day count to a March-based day count shifted up by 39 eras.
    localparam logic [23:0] DAY_BIAS = 24'd54336;
    // Biased day count to a count whose remainder by 7 is the weekday.
    localparam logic [23:0] WD_BIAS  = 24'd5;

    localparam logic [17:0] ERA_DAYS   = 18'd146097;
    localparam logic [17:0] ERA_LAST   = 18'd146096;
    localparam int unsigned ERA_SHIFT  = 42;
    localparam logic [24:0] ERA_MUL    =
        25'(((64'd1 << ERA_SHIFT) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;

    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam int unsigned HOUR_SHIFT   = 29;
    localparam logic [17:0] HOUR_MUL     =
        18'(((64'd1 << HOUR_SHIFT) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR));

    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam int unsigned MIN_SHIFT    = 18;
    localparam logic [12:0] MIN_MUL      =
        13'(((64'd1 << MIN_SHIFT) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));

    localparam logic [2:0]  WEEK_DAYS    = 3'd7;
    localparam int unsigned WEEK_SHIFT   = 27;
    localparam logic [24:0] WEEK_MUL     =
        25'(((64'd1 << WEEK_SHIFT) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

    localparam logic [10:0] DAYS_4Y      = 11'd1460;
    localparam int unsigned D4Y_SHIFT    = 29;
    localparam logic [18:0] D4Y_MUL      =
        19'(((64'd1 << D4Y_SHIFT) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    localparam logic [15:0] DAYS_100Y    = 16'd36524;
    localparam int unsigned D100Y_SHIFT  = 34;
    localparam logic [18:0] D100Y_MUL    =
        19'(((64'd1 << D100Y_SHIFT) + 64'(DAYS_100Y) - 64'd1) / 64'(DAYS_100Y));

    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam int unsigned YEAR_SHIFT    = 27;
    localparam logic [18:0] YEAR_MUL      =
        19'(((64'd1 << YEAR_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

    localparam logic [7:0]  MP_DIV   = 8'd153;
    localparam int unsigned MP_SHIFT = 19;
    localparam logic [11:0] MP_MUL   =
        12'(((64'd1 << MP_SHIFT) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

    // March-based months from this index on (January and February) roll into the next calendar year.
    localparam logic [3:0]  MP_JANUARY  = 4'd10;
    localparam logic [16:0] YEAR_OFFSET = 17'd17500;

    typedef struct packed {
        logic [23:0] zb;
        logic [23:0] wdx;
        logic [16:0] sod;
    } day_t;

    typedef struct packed {
        logic [17:0] doe;
        logic [15:0] era400;
        logic [11:0] mrem;
        logic [4:0]  hour;
        logic [2:0]  wd;
    } fld_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wd;
    } res_t;

    // First day of each March-based month within the March-based year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        unique case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

/* rtl/eso_day_split.sv */
// Front pipeline: biased epoch seconds to day count and second of day.
// Five stages; depends on eso_pkg.
module eso_day_split (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [39:0]        in_secs,
    output logic               out_valid,
    input  logic               out_ready,
    output eso_pkg::day_t      out_data
);

    localparam int unsigned NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    logic [40:0] u_next;
    logic [40:0] u_reg;

    logic [34:0] q1_prod;
    logic [7:0]  q1_reg;
    logic [16:0] a_reg;
    logic [16:0] b_reg;
    logic [6:0]  low7_b_reg;

    logic [16:0] r1_full;
    logic [26:0] t_next;
    logic [26:0] t_reg;
    logic [7:0]  q1_c_reg;
    logic [6:0]  low7_c_reg;

    logic [53:0] q2_prod;
    logic [16:0] q2_reg;
    logic [26:0] t_d_reg;
    logic [7:0]  q1_d_reg;
    logic [6:0]  low7_d_reg;

    logic [26:0]   r2_full;
    logic [23:0]   days_u;
    eso_pkg::day_t out_next;
    eso_pkg::day_t out_reg;

    always_comb begin
        rdy[NSTG-1] = ~vld_reg[NSTG-1] | out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Sign-extended input plus a whole-day bias, always non-negative.
    assign u_next = {in_secs[39], in_secs} + eso_pkg::SEC_BIAS;

    // High part of (u >> 7) divided by 675.
    assign q1_prod = 35'(u_reg[40:24]) * 35'(eso_pkg::HI_MUL);

    assign r1_full = a_reg - 17'(q1_reg) * 17'(eso_pkg::SEC_DIV_ODD);
    assign t_next  = {r1_full[9:0], b_reg};

    assign q2_prod = 54'(t_reg) * 54'(eso_pkg::LO_MUL);

    assign r2_full = t_d_reg - 27'(q2_reg) * 27'(eso_pkg::SEC_DIV_ODD);
    assign days_u  = {q1_d_reg[6:0], q2_reg};

    always_comb begin
        out_next.zb  = days_u + eso_pkg::DAY_BIAS;
        out_next.wdx = days_u + eso_pkg::WD_BIAS;
        out_next.sod = {r2_full[9:0], low7_d_reg};
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            u_reg <= u_next;
        end
        if (rdy[1]) begin
            q1_reg     <= q1_prod[eso_pkg::HI_SHIFT +: 8];
            a_reg      <= u_reg[40:24];
            b_reg      <= u_reg[23:7];
            low7_b_reg <= u_reg[6:0];
        end
        if (rdy[2]) begin
            t_reg      <= t_next;
            q1_c_reg   <= q1_reg;
            low7_c_reg <= low7_b_reg;
        end
        if (rdy[3]) begin
            q2_reg     <= q2_prod[eso_pkg::LO_SHIFT +: 17];
            t_d_reg    <= t_reg;
            q1_d_reg   <= q1_c_reg;
            low7_d_reg <= low7_c_reg;
        end
        if (rdy[4]) begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

/* rtl/eso_day_fields.sv */
// Middle pipeline: era and day of era, hour and remaining seconds, weekday.
// Two stages; depends on eso_pkg.
module eso_day_fields (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  eso_pkg::day_t      in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output eso_pkg::fld_t      out_data
);

    localparam int unsigned NSTG = 2;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    logic [48:0] era_prod;
    logic [34:0] hour_prod;
    logic [48:0] wdq_prod;

    logic [6:0]    era_q_reg;
    logic [4:0]    hour_reg;
    logic [21:0]   wdq_reg;
    eso_pkg::day_t day_reg;

    logic [23:0]   doe_full;
    logic [16:0]   mrem_full;
    logic [23:0]   wd_full;
    eso_pkg::fld_t out_next;
    eso_pkg::fld_t out_reg;

    always_comb begin
        rdy[NSTG-1] = ~vld_reg[NSTG-1] | out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign era_prod  = 49'(in_data.zb)  * 49'(eso_pkg::ERA_MUL);
    assign hour_prod = 35'(in_data.sod) * 35'(eso_pkg::HOUR_MUL);
    assign wdq_prod  = 49'(in_data.wdx) * 49'(eso_pkg::WEEK_MUL);

    assign doe_full  = day_reg.zb  - 24'(era_q_reg) * 24'(eso_pkg::ERA_DAYS);
    assign mrem_full = day_reg.sod - 17'(hour_reg)  * 17'(eso_pkg::SEC_PER_HOUR);
    assign wd_full   = day_reg.wdx - 24'(wdq_reg)   * 24'(eso_pkg::WEEK_DAYS);

    always_comb begin
        out_next.doe    = doe_full[17:0];
        out_next.era400 = 16'(era_q_reg) * 16'(eso_pkg::YEARS_PER_ERA);
        out_next.mrem   = mrem_full[11:0];
        out_next.hour   = hour_reg;
        out_next.wd     = wd_full[2:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            era_q_reg <= era_prod[eso_pkg::ERA_SHIFT +: 7];
            hour_reg  <= hour_prod[eso_pkg::HOUR_SHIFT +: 5];
            wdq_reg   <= wdq_prod[eso_pkg::WEEK_SHIFT +: 22];
            day_reg   <= in_data;
        end
        if (rdy[1]) begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

/* rtl/eso_civil.sv */
// Back pipeline: year of era, day of year, month, day of month, minute and
// second, and the final result register. Six stages; depends on eso_pkg.
module eso_civil (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  eso_pkg::fld_t      in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output eso_pkg::res_t      out_data
);

    localparam int unsigned NSTG = 6;

    typedef struct packed {
        logic [15:0] era400;
        logic [4:0]  hour;
        logic [2:0]  wd;
    } carry_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    carry_t      carry_in;
    carry_t      carry_h_reg;
    carry_t      carry_i_reg;
    carry_t      carry_j_reg;
    carry_t      carry_k_reg;
    carry_t      carry_l_reg;

    logic [36:0] c4y_prod;
    logic [36:0] c100y_prod;
    logic [24:0] min_prod;

    logic [17:0] doe_h_reg;
    logic [6:0]  c4y_reg;
    logic [2:0]  c100y_reg;
    logic        clast_reg;
    logic [5:0]  minute_h_reg;
    logic [11:0] mrem_h_reg;

    logic [17:0] n_next;
    logic [11:0] sec_full;
    logic [17:0] n_reg;
    logic [17:0] doe_i_reg;
    logic [5:0]  minute_i_reg;
    logic [5:0]  second_i_reg;

    logic [36:0] yoe_prod;
    logic [8:0]  yoe_j_reg;
    logic [17:0] doe_j_reg;
    logic [5:0]  minute_j_reg;
    logic [5:0]  second_j_reg;

    logic [1:0]  c_cent;
    logic [17:0] year_base;
    logic [17:0] doy_full;
    logic [8:0]  doy_k_reg;
    logic [8:0]  yoe_k_reg;
    logic [5:0]  minute_k_reg;
    logic [5:0]  second_k_reg;

    logic [10:0] mp_arg;
    logic [22:0] mp_prod;
    logic [3:0]  mp_reg;
    logic [8:0]  doy_l_reg;
    logic [8:0]  yoe_l_reg;
    logic [5:0]  minute_l_reg;
    logic [5:0]  second_l_reg;

    logic [8:0]    mday_full;
    logic [16:0]   year_full;
    logic          jan_feb;
    eso_pkg::res_t out_next;
    eso_pkg::res_t out_reg;

    always_comb begin
        rdy[NSTG-1] = ~vld_reg[NSTG-1] | out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_comb begin
        carry_in.era400 = in_data.era400;
        carry_in.hour   = in_data.hour;
        carry_in.wd     = in_data.wd;
    end

    // Leap-day corrections: four-year cycles, centuries and the last day of the era.
    assign c4y_prod   = 37'(in_data.doe)  * 37'(eso_pkg::D4Y_MUL);
    assign c100y_prod = 37'(in_data.doe)  * 37'(eso_pkg::D100Y_MUL);
    assign min_prod   = 25'(in_data.mrem) * 25'(eso_pkg::MIN_MUL);

    assign n_next   = doe_h_reg - 18'(c4y_reg) + 18'(c100y_reg) - 18'(clast_reg);
    assign sec_full = mrem_h_reg - 12'(minute_h_reg) * 12'(eso_pkg::SEC_PER_MIN);

    assign yoe_prod = 37'(n_reg) * 37'(eso_pkg::YEAR_MUL);

    // Year of era is below 400, so its century count comes from three compares.
    always_comb begin
        priority if (yoe_j_reg >= 9'd300) c_cent = 2'd3;
        else if (yoe_j_reg >= 9'd200)     c_cent = 2'd2;
        else if (yoe_j_reg >= 9'd100)     c_cent = 2'd1;
        else                              c_cent = 2'd0;
    end

    assign year_base = 18'(yoe_j_reg) * 18'(eso_pkg::DAYS_PER_YEAR)
                     + 18'(yoe_j_reg[8:2]) - 18'(c_cent);
    assign doy_full  = doe_j_reg - year_base;

    assign mp_arg  = {doy_k_reg, 2'b00} + 11'(doy_k_reg) + 11'd2;
    assign mp_prod = 23'(mp_arg) * 23'(eso_pkg::MP_MUL);

    assign jan_feb   = (mp_reg >= eso_pkg::MP_JANUARY);
    assign mday_full = doy_l_reg - eso_pkg::month_start(mp_reg) + 9'd1;
    assign year_full = 17'(yoe_l_reg) + 17'(carry_l_reg.era400) + 17'(jan_feb)
                     - eso_pkg::YEAR_OFFSET;

    always_comb begin
        out_next.year   = year_full[15:0];
        out_next.month  = jan_feb ? (mp_reg - eso_pkg::MP_JANUARY) : (mp_reg + 4'd2);
        out_next.mday   = mday_full[4:0];
        out_next.hour   = carry_l_reg.hour;
        out_next.minute = minute_l_reg;
        out_next.second = second_l_reg;
        out_next.wd     = carry_l_reg.wd;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            doe_h_reg    <= in_data.doe;
            c4y_reg      <= c4y_prod[eso_pkg::D4Y_SHIFT +: 7];
            c100y_reg    <= c100y_prod[eso_pkg::D100Y_SHIFT +: 3];
            clast_reg    <= (in_data.doe == eso_pkg::ERA_LAST);
            minute_h_reg <= min_prod[eso_pkg::MIN_SHIFT +: 6];
            mrem_h_reg   <= in_data.mrem;
            carry_h_reg  <= carry_in;
        end
        if (rdy[1]) begin
            n_reg        <= n_next;
            doe_i_reg    <= doe_h_reg;
            minute_i_reg <= minute_h_reg;
            second_i_reg <= sec_full[5:0];
            carry_i_reg  <= carry_h_reg;
        end
        if (rdy[2]) begin
            yoe_j_reg    <= yoe_prod[eso_pkg::YEAR_SHIFT +: 9];
            doe_j_reg    <= doe_i_reg;
            minute_j_reg <= minute_i_reg;
            second_j_reg <= second_i_reg;
            carry_j_reg  <= carry_i_reg;
        end
        if (rdy[3]) begin
            doy_k_reg    <= doy_full[8:0];
            yoe_k_reg    <= yoe_j_reg;
            minute_k_reg <= minute_j_reg;
            second_k_reg <= second_j_reg;
            carry_k_reg  <= carry_j_reg;
        end
        if (rdy[4]) begin
            mp_reg       <= mp_prod[eso_pkg::MP_SHIFT +: 4];
            doy_l_reg    <= doy_k_reg;
            yoe_l_reg    <= yoe_k_reg;
            minute_l_reg <= minute_k_reg;
            second_l_reg <= second_k_reg;
            carry_l_reg  <= carry_k_reg;
        end
        if (rdy[5]) begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

/* rtl/epoch_seconds_to_utc_date_unit.sv */
// Converts signed epoch seconds into a broken-down proleptic Gregorian UTC
// date and time. The unit is a 13-stage pipeline that accepts one transfer per
// clock while the output is not stalled; all divisions are by constants and
// are done as multiplications by reciprocals, with at most one multiplication
// in series in any stage. Every stage has its own valid bit and a stage
// accepts new data whenever it is empty or its successor moves, so bubbles
// collapse and a stalled output holds up to 13 results in flight while
// inputs keep flowing until the pipeline is full.
// Depends on eso_pkg, eso_day_split, eso_day_fields and eso_civil.
module epoch_seconds_to_utc_date_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [39:0] epoch_seconds (signed)
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] year_since_1900 (signed), [19:16] month_index, [24:20] day_of_month,
    // [29:25] hour_of_day, [35:30] minute_of_hour, [41:36] second_of_minute,
    // [44:42] weekday, [47:45] zero
    output logic [47:0] m_tdata
);

    logic          day_valid;
    logic          day_ready;
    eso_pkg::day_t day_data;

    logic          fld_valid;
    logic          fld_ready;
    eso_pkg::fld_t fld_data;

    eso_pkg::res_t res_data;

    eso_day_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_secs   (s_tdata),
        .out_valid (day_valid),
        .out_ready (day_ready),
        .out_data  (day_data)
    );

    eso_day_fields u_fields (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (day_valid),
        .in_ready  (day_ready),
        .in_data   (day_data),
        .out_valid (fld_valid),
        .out_ready (fld_ready),
        .out_data  (fld_data)
    );

    eso_civil u_civil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fld_valid),
        .in_ready  (fld_ready),
        .in_data   (fld_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = {3'b000, res_data.wd, res_data.second, res_data.minute,
                      res_data.hour, res_data.mday, res_data.month, res_data.year};

endmodule

/* verif/epoch_seconds_to_utc_date_unit_tb.sv */
// Self-checking testbench for epoch_seconds_to_utc_date_unit.
// It predicts each date in the testbench and compares it with the block's result stream.
// It depends only on the unit's RTL and drives both stream sides with random idle cycles.
`timescale 1ns / 1ps

module epoch_seconds_to_utc_date_unit_tb;

    localparam longint SECS_PER_DAY   = 86400;
    localparam longint SECS_PER_HOUR  = 3600;
    localparam longint SECS_PER_MIN   = 60;
    localparam longint MARCH_EPOCH    = 719468;  // days from 0000-03-01 to 1970-01-01
    localparam longint DAYS_PER_ERA   = 146097;
    localparam longint STAMP_MAX      = 64'sd549755813887;
    localparam longint STAMP_MIN      = -64'sd549755813888;
    localparam int     IDLE_LIMIT     = 2000;
    localparam int     DRAIN_CYCLES   = 64;
    localparam int     REPORT_LIMIT   = 100;

    typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    typedef struct {
        logic [39:0]        stamp;
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         mday;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         sec;
        logic [2:0]         wday;
    } utc_date_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    utc_date_t date_q[$];
    int        stamps_sent;
    int        dates_checked;
    int        mismatches;
    int        idle_cycles;
    int        burst_left;
    bit        sender_gaps;
    rx_mode_t  rx_mode;
    int        rx_left;
    int        rx_phase;

    epoch_seconds_to_utc_date_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Floor division throughout, so that times before the epoch land on the right day.
    function automatic utc_date_t civil_date_of(input logic [39:0] stamp);
        utc_date_t d;
        longint    secs, days, sod, shifted, era, doe, yoe, doy, mp, mon, yr, wd;
        secs = longint'($signed(stamp));
        days = secs / SECS_PER_DAY;
        sod  = secs % SECS_PER_DAY;
        if (sod < 0) begin
            sod  += SECS_PER_DAY;
            days -= 1;
        end
        shifted = days + MARCH_EPOCH;
        era = shifted / DAYS_PER_ERA;
        doe = shifted % DAYS_PER_ERA;
        if (doe < 0) begin
            doe += DAYS_PER_ERA;
            era -= 1;
        end
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        yr  = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
        wd  = (days + 4) % 7;
        if (wd < 0) wd += 7;
        d.stamp  = stamp;
        d.year   = 16'(yr - 1900);
        d.month  = 4'(mon - 1);
        d.mday   = 5'(doy - (153 * mp + 2) / 5 + 1);
        d.hour   = 5'(sod / SECS_PER_HOUR);
        d.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
        d.sec    = 6'(sod % SECS_PER_MIN);
        d.wday   = 3'(wd);
        return d;
    endfunction

    task automatic report_field(input string name, input logic [39:0] stamp,
                                input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s for stamp %0d: expected %0d, actual %0d",
                         $time, name, $signed(stamp), want, got);
        end
    endtask

    // Sender: bursts of random length, separated by random idle gaps when sender_gaps is set.
    task automatic send_epoch(input longint secs);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps)
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 3);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs[39:0];
        do @(posedge aclk); while (!s_tready);
        date_q.push_back(civil_date_of(secs[39:0]));
        stamps_sent++;
    endtask

    // Receiver: stall behavior switches among several patterns every so often.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_BUSY:     m_tready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE:   m_tready <= ($urandom_range(0, 9) < 2);
            RX_PERIODIC: m_tready <= ((rx_phase % 11) < 6);
            default:     m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        utc_date_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (date_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with no pending stamp: expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = date_q.pop_front();
                dates_checked++;
                report_field("year_since_1900", want.stamp, want.year,
                             $signed(m_tdata[15:0]));
                report_field("month_index", want.stamp, want.month, m_tdata[19:16]);
                report_field("day_of_month", want.stamp, want.mday, m_tdata[24:20]);
                report_field("hour_of_day", want.stamp, want.hour, m_tdata[29:25]);
                report_field("minute_of_hour", want.stamp, want.minute, m_tdata[35:30]);
                report_field("second_of_minute", want.stamp, want.sec, m_tdata[41:36]);
                report_field("weekday", want.stamp, want.wday, m_tdata[44:42]);
                report_field("padding", want.stamp, 0, m_tdata[47:45]);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, date_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Field extremes, epoch neighbors, leap days, century rules and the range ends.
    task automatic test_directed();
        longint stamps[$];
        sender_gaps = 1'b0;
        stamps = '{0, 1, -1, 59, 3599, 86399, 86400, -86400, -86401,
                   951696000, 951782399, 951782400,           // 2000 leap day
                   -64'sd2203891201, -64'sd2203891200,        // 1900 has no Feb 29
                   64'sd4102444800, 64'sd2147483648, 64'sd253402300799,
                   -64'sd62162035201, -64'sd62162035200,      // March 1st of year 0
                   STAMP_MAX, STAMP_MAX - 1, STAMP_MIN, STAMP_MIN + 1};
        foreach (stamps[i]) send_epoch(stamps[i]);
    endtask

    task automatic test_full_range(input int count);
        longint secs;
        sender_gaps = 1'b1;
        for (int i = 0; i < count; i++) begin
            secs = longint'({8'($urandom_range(0, 255)), 32'($urandom())});
            send_epoch(secs);
        end
    endtask

    task automatic test_near_epoch(input int count);
        sender_gaps = ($urandom_range(0, 1) == 1);
        for (int i = 0; i < count; i++)
            send_epoch(longint'($signed(32'($urandom()))));
    endtask

    // Random days with seconds just around midnight, or at a random second of the day.
    task automatic test_day_edges(input int count);
        longint days, secs;
        int     pick;
        sender_gaps = 1'b1;
        for (int i = 0; i < count; i++) begin
            days = longint'($urandom_range(0, 12725828)) - 6362914;
            pick = $urandom_range(0, 4);
            secs = days * SECS_PER_DAY;
            case (pick)
                0: secs -= 1;
                1: secs += 1;
                2: secs += SECS_PER_DAY - 1;
                3: secs += $urandom_range(0, 86399);
                default: ;
            endcase
            send_epoch(secs);
        end
    endtask

    // March 1st, Feb 28/29 and New Year of random years in random 400-year eras.
    task automatic test_year_edges(input int count);
        longint era, yoe, doe, days, secs;
        longint shifts[5];
        sender_gaps = 1'b1;
        shifts = '{-2, -1, 0, 305, 306};
        for (int i = 0; i < count; i++) begin
            era  = longint'($urandom_range(0, 87)) - 39;
            yoe  = (i % 5 == 0) ? 100 * $urandom_range(0, 3) : $urandom_range(0, 399);
            doe  = 365 * yoe + yoe / 4 - yoe / 100;
            days = era * DAYS_PER_ERA + doe + shifts[$urandom_range(0, 4)] - MARCH_EPOCH;
            case ($urandom_range(0, 3))
                0: secs = days * SECS_PER_DAY;
                1: secs = days * SECS_PER_DAY + SECS_PER_DAY - 1;
                default: secs = days * SECS_PER_DAY + $urandom_range(0, 86399);
            endcase
            send_epoch(secs);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        rx_mode     = RX_OPEN;
        rx_left     = 0;
        rx_phase    = 0;
        burst_left  = 0;
        sender_gaps = 1'b0;
        stamps_sent = 0;
        dates_checked = 0;
        mismatches  = 0;
        idle_cycles = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_full_range(500);
        test_near_epoch(300);
        test_day_edges(300);
        test_year_edges(500);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (date_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d timestamps and checked %0d dates: range ends, full-range,",
                 stamps_sent, dates_checked);
        $display("near-epoch, midnight and leap-year/century boundaries; %0d field errors.",
                 mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
